>>> rtl/core/jkiss32_random_generator_assert.svh
// assertion helpers for the jkiss32 generator
`ifndef JKISS32_RANDOM_GENERATOR_ASSERT_SVH
`define JKISS32_RANDOM_GENERATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define JK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/jkiss32_pkg.sv
`default_nettype none
package jkiss32_pkg;

  localparam int unsigned WARMUP_STEPS = 20;
  localparam int unsigned CNT_W        = 7;

  localparam logic [31:0] ADD_INC    = 32'd1411392427;
  localparam logic [31:0] MASK31     = 32'h7FFF_FFFF;
  localparam logic [31:0] ADD_RST    = 32'd123456789;
  localparam logic [31:0] SHIFT_RST  = 32'd987654321;
  localparam logic [31:0] LOW_RST    = 32'd345678912;
  localparam logic [30:0] HIGH_RST   = 31'd456789123;

  localparam logic [CNT_W-1:0] WARMUP_CNT = CNT_W'(WARMUP_STEPS);

  localparam logic REQ_NEXT = 1'b0;
  localparam logic REQ_SEED = 1'b1;

  typedef struct packed {
    logic [31:0] add_word;
    logic [31:0] shift_word;
    logic [31:0] carry_low;   // 32 bits: first warm-up step uses the whole seed
    logic [30:0] carry_high;
    logic        carry_bit;
  } gen_state_t;

  function automatic gen_state_t gen_advance(gen_state_t s);
    gen_state_t  n;
    logic [31:0] x;
    logic [31:0] t;
    x = s.shift_word;
    x = x ^ (x << 5);
    x = x ^ (x >> 7);
    x = x ^ (x << 22);
    t = s.carry_low + {1'b0, s.carry_high} + {31'd0, s.carry_bit};
    n.shift_word = x;
    n.carry_low  = {1'b0, s.carry_high};
    n.carry_bit  = t[31];
    n.carry_high = t[30:0];
    n.add_word   = s.add_word + ADD_INC;
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/jkiss32_random_generator.sv
// jkiss32 random word generator
// input channel: in_valid/in_ready with in_req_type and in_seed_value.
//   a next request advances the state once and yields one word on out_random_word.
//   a seed request loads add, xorshift and carry-low words with the seed, then
//   runs WARMUP_STEPS warm-up steps with in_ready low; it yields no word.
// output channel: out_valid/out_ready with out_random_word, held in an output register.
// output timing: a next request accepted at one edge shows its word at the output
//   right after that edge, from the output register.
// throughput: one next request per cycle while no warm-up runs and the output word
//   can leave; the single state update between the state registers and the output
//   register allows it. a seed request occupies the block for the load and the
//   WARMUP_STEPS warm-up steps, counted by the warm-up counter. while the output
//   word waits, a new next request is taken only in the cycle the word leaves; seed requests are taken regardless.
// reset: synchronous, active low; state returns to the fixed default words,
//   the output register is emptied and the warm-up counter is cleared.
`default_nettype none
`include "jkiss32_random_generator_assert.svh"

module jkiss32_random_generator
  import jkiss32_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_random_word
);

  gen_state_t       st_r, st_nxt, st_adv;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      word_r, word_nxt;
  logic             busy;
  logic             in_fire;
  logic             out_fire;

  assign busy     = (cnt_r != '0);
  assign out_fire = out_valid_r && out_ready;
  assign in_ready = !busy && ((in_req_type == REQ_SEED) || !out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign st_adv   = gen_advance(st_r);

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_fire;
    word_nxt      = word_r;
    if (busy) begin
      st_nxt  = st_adv;
      cnt_nxt = cnt_r - 1'b1;
    end else if (in_fire) begin
      if (in_req_type == REQ_SEED) begin
        st_nxt.add_word   = in_seed_value;
        st_nxt.shift_word = in_seed_value;
        // the whole seed feeds the first carry step, if there is one
        st_nxt.carry_low  = (WARMUP_CNT == '0) ? (in_seed_value & MASK31) : in_seed_value;
        cnt_nxt           = WARMUP_CNT;
      end else begin
        st_nxt        = st_adv;
        out_valid_nxt = 1'b1;
        word_nxt      = st_adv.add_word + st_adv.shift_word + {1'b0, st_adv.carry_high};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.add_word   <= ADD_RST;
      st_r.shift_word <= SHIFT_RST;
      st_r.carry_low  <= LOW_RST;
      st_r.carry_high <= HIGH_RST;
      st_r.carry_bit  <= 1'b0;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = word_r;

  `JK_ASSERT_NOW(a_busy_blocks_input, busy, !in_ready, "input taken during warm-up")
  `JK_ASSERT_NEXT(a_warmup_counts_down, busy, cnt_r == $past(cnt_r) - 1'b1,
                  "warm-up counter skipped")
  `JK_ASSERT_NEXT(a_zero_shift_sticks, (st_r.shift_word == '0) && !in_fire,
                  st_r.shift_word == '0, "xorshift word left zero")
  `JK_ASSERT_NEXT(a_word_drains, out_fire && !(in_fire && (in_req_type == REQ_NEXT)),
                  !out_valid_r, "word repeated after delivery")

endmodule
`default_nettype wire
